/* rtl/ar3d_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine table builder for the
// axis rotation block. Depends on nothing; every other file imports it.

package ar3d_pkg;

	// Field widths.
	localparam int ANGLE_BITS   = 16;
	localparam int ELEMENT_BITS = 32;
	localparam int OP_BITS      = 2;
	localparam int THR_BITS     = 10;

	// Configuration port.
	localparam int DATA_BITS      = 32;
	localparam int PADDR_BITS     = 3;
	localparam int REG_INDEX_BITS = PADDR_BITS - 2;
	localparam logic [REG_INDEX_BITS-1:0] REG_ZERO_THRESHOLD = '0;

	// Phase quantization: the angle is scaled to 24 bits, the top 12 form the phase.
	localparam int SCALED_BITS  = 24;
	localparam int PHASE_BITS   = 12;
	localparam int QUARTER_BITS = 10;
	localparam int QUARTER_STEPS = 1 << QUARTER_BITS;
	localparam int INDEX_BITS   = QUARTER_BITS + 1;

	// Sine table storage split into banks small enough to read as logic.
	localparam int SINE_BITS  = 15;
	localparam int BANK_BITS  = 8;
	localparam int BANK_DEPTH = 1 << BANK_BITS;
	localparam int BANK_COUNT = QUARTER_STEPS / BANK_DEPTH;
	localparam int BANK_SEL_BITS = QUARTER_BITS - BANK_BITS;

	// Arithmetic widths.
	localparam int COEF_BITS  = 17;
	localparam int FRAC_BITS  = 15;
	localparam int PROD_BITS  = COEF_BITS + ELEMENT_BITS;
	localparam int ROUND_BITS = PROD_BITS - FRAC_BITS;
	localparam int SUM_BITS   = ROUND_BITS + 1;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [OP_BITS-1:0] {
		OP_ROLL,
		OP_PITCH,
		OP_YAW,
		OP_IDENT
	} op_t;

	typedef logic signed [ELEMENT_BITS-1:0] elem_t;
	typedef logic signed [COEF_BITS-1:0]    coef_t;
	typedef logic signed [PROD_BITS-1:0]    prod_t;
	typedef logic signed [ROUND_BITS-1:0]   rnd_t;
	typedef logic signed [SUM_BITS-1:0]     sum_t;
	typedef logic [SINE_BITS-1:0]           sine_t;
	typedef sine_t                          sine_bank_t [BANK_DEPTH];

	localparam elem_t ELEM_MAX = {1'b0, {(ELEMENT_BITS-1){1'b1}}};
	localparam elem_t ELEM_MIN = {1'b1, {(ELEMENT_BITS-1){1'b0}}};
	localparam coef_t COEF_ONE = coef_t'(1 << FRAC_BITS);
	localparam prod_t PROD_HALF = prod_t'(1 << (FRAC_BITS - 1));

	// Per-stage advance strobes of the pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	// Operands of one lane: c1 * e1 + c2 * e2.
	typedef struct packed {
		coef_t c1;
		elem_t e1;
		coef_t c2;
		elem_t e2;
	} lane_op_t;

	// One unsigned Q0.15 entry sin(k*pi/2048) from a Q30 Taylor series, evaluated at elaboration.
	function automatic sine_t quarter_sine(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		x    = (longint'(k) * HALF_PI_Q30 + 64'd512) >> 10;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		term = ((term * x2) >> 30) / 6;
		acc  = acc - longint'(term);
		term = ((term * x2) >> 30) / 20;
		acc  = acc + longint'(term);
		term = ((term * x2) >> 30) / 42;
		acc  = acc - longint'(term);
		term = ((term * x2) >> 30) / 72;
		acc  = acc + longint'(term);
		term = ((term * x2) >> 30) / 110;
		acc  = acc - longint'(term);
		term = ((term * x2) >> 30) / 156;
		acc  = acc + longint'(term);
		term = ((term * x2) >> 30) / 210;
		acc  = acc - longint'(term);
		if (acc < 0) begin
			acc = 0;
		end
		acc = (acc + 16384) >>> 15;
		if (acc > 32767) begin
			acc = 32767;
		end
		return acc[SINE_BITS-1:0];
	endfunction

	// One bank of consecutive table entries starting at bank * BANK_DEPTH.
	function automatic sine_bank_t build_bank(input int unsigned bank);
		sine_bank_t b;
		for (int unsigned j = 0; j < BANK_DEPTH; j++) begin
			b[j] = quarter_sine(bank * BANK_DEPTH + j);
		end
		return b;
	endfunction

endpackage

/* rtl/ar3d_in_if.sv */
`timescale 1ns / 1ps
// Input channel carrying one row item: axis selector, angle and three elements.
// Depends on ar3d_pkg.

interface ar3d_in_if import ar3d_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [OP_BITS-1:0]    operation;
	logic [ANGLE_BITS-1:0] angle;
	elem_t                 row_x;
	elem_t                 row_y;
	elem_t                 row_z;

	modport source (output valid, operation, angle, row_x, row_y, row_z, input ready);
	modport sink (input valid, operation, angle, row_x, row_y, row_z, output ready);
endinterface

/* rtl/ar3d_out_if.sv */
`timescale 1ns / 1ps
// Output channel carrying one rotated row item.
// Depends on ar3d_pkg.

interface ar3d_out_if import ar3d_pkg::*; ();
	logic  valid;
	logic  ready;
	elem_t out_x;
	elem_t out_y;
	elem_t out_z;

	modport source (output valid, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

/* rtl/ar3d_sincos.sv */
`timescale 1ns / 1ps
// Sine and cosine lookup: binary angle to Q1.15 pair over two pipeline stages.
// Depends on ar3d_pkg for the table builder and widths.

module ar3d_sincos import ar3d_pkg::*; (
	input  logic                  clk,
	input  stage_en_t             en,
	input  logic [ANGLE_BITS-1:0] angle,
	output coef_t                 sin_s2,
	output coef_t                 cos_s2
);

	localparam sine_bank_t SINE_BANK0 = build_bank(0);
	localparam sine_bank_t SINE_BANK1 = build_bank(1);
	localparam sine_bank_t SINE_BANK2 = build_bank(2);
	localparam sine_bank_t SINE_BANK3 = build_bank(3);
	localparam sine_t      SINE_TOP   = quarter_sine(QUARTER_STEPS);

	logic [SCALED_BITS-1:0]   scaled;
	logic [PHASE_BITS-1:0]    phase;
	logic [INDEX_BITS-1:0]    idx_a;
	logic [INDEX_BITS-1:0]    idx_b;

	sine_t                    ta_s1 [BANK_COUNT];
	sine_t                    tb_s1 [BANK_COUNT];
	logic [BANK_SEL_BITS-1:0] asel_s1;
	logic [BANK_SEL_BITS-1:0] bsel_s1;
	logic                     btop_s1;
	logic [1:0]               quad_s1;

	sine_t                    val_a;
	sine_t                    val_b;
	sine_t                    sin_mag;
	sine_t                    cos_mag;
	logic                     cos_neg;

	// Phase index and the two table addresses: r and a quarter turn minus r.
	always_comb begin
		scaled = SCALED_BITS'(angle) << (SCALED_BITS - ANGLE_BITS);
		phase  = scaled[SCALED_BITS-1 -: PHASE_BITS];
		idx_a  = {1'b0, phase[QUARTER_BITS-1:0]};
		idx_b  = INDEX_BITS'(QUARTER_STEPS) - idx_a;
	end

	// Stage 1: read every bank at both addresses.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			ta_s1[0] <= SINE_BANK0[idx_a[BANK_BITS-1:0]];
			ta_s1[1] <= SINE_BANK1[idx_a[BANK_BITS-1:0]];
			ta_s1[2] <= SINE_BANK2[idx_a[BANK_BITS-1:0]];
			ta_s1[3] <= SINE_BANK3[idx_a[BANK_BITS-1:0]];
			tb_s1[0] <= SINE_BANK0[idx_b[BANK_BITS-1:0]];
			tb_s1[1] <= SINE_BANK1[idx_b[BANK_BITS-1:0]];
			tb_s1[2] <= SINE_BANK2[idx_b[BANK_BITS-1:0]];
			tb_s1[3] <= SINE_BANK3[idx_b[BANK_BITS-1:0]];
			asel_s1  <= idx_a[QUARTER_BITS-1:BANK_BITS];
			bsel_s1  <= idx_b[QUARTER_BITS-1:BANK_BITS];
			btop_s1  <= idx_b[QUARTER_BITS];
			quad_s1  <= phase[PHASE_BITS-1 -: 2];
		end
	end

	// Odd quadrants mirror the table; cosine is sine one quadrant on.
	always_comb begin
		val_a   = ta_s1[asel_s1];
		val_b   = btop_s1 ? SINE_TOP : tb_s1[bsel_s1];
		sin_mag = quad_s1[0] ? val_b : val_a;
		cos_mag = quad_s1[0] ? val_a : val_b;
		cos_neg = quad_s1[1] ^ quad_s1[0];
	end

	// Stage 2: signed sine and cosine.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			sin_s2 <= quad_s1[1] ? -coef_t'({2'b00, sin_mag}) : coef_t'({2'b00, sin_mag});
			cos_s2 <= cos_neg ? -coef_t'({2'b00, cos_mag}) : coef_t'({2'b00, cos_mag});
		end
	end

endmodule

/* rtl/ar3d_lane.sv */
`timescale 1ns / 1ps
// One arithmetic lane: two products, rounding, sum and saturation.
// Depends on ar3d_pkg for widths and the operand struct.

module ar3d_lane import ar3d_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  lane_op_t  opnd,
	output elem_t     sat_s4
);

	prod_t p1_s3;
	prod_t p2_s3;
	prod_t p1_half;
	prod_t p2_half;
	rnd_t  r1;
	rnd_t  r2;
	sum_t  sum;
	elem_t sat;

	// Stage 3: the two products.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			p1_s3 <= prod_t'(opnd.c1) * prod_t'(opnd.e1);
			p2_s3 <= prod_t'(opnd.c2) * prod_t'(opnd.e2);
		end
	end

	// Round each product to nearest, halves up, then add and clamp.
	always_comb begin
		p1_half = p1_s3 + PROD_HALF;
		p2_half = p2_s3 + PROD_HALF;
		r1      = p1_half[PROD_BITS-1:FRAC_BITS];
		r2      = p2_half[PROD_BITS-1:FRAC_BITS];
		sum     = sum_t'(r1) + sum_t'(r2);
		if (sum > sum_t'(ELEM_MAX)) begin
			sat = ELEM_MAX;
		end else if (sum < sum_t'(ELEM_MIN)) begin
			sat = ELEM_MIN;
		end else begin
			sat = sum[ELEMENT_BITS-1:0];
		end
	end

	// Stage 4: saturated lane result.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			sat_s4 <= sat;
		end
	end

endmodule

/* rtl/ar3d_merge.sv */
`timescale 1ns / 1ps
// Merging stage: applies the zero threshold to the three lanes and holds the
// result item in the output register. Depends on ar3d_pkg.

module ar3d_merge import ar3d_pkg::*; (
	input  logic                clk,
	input  stage_en_t           en,
	input  logic [THR_BITS-1:0] threshold,
	input  elem_t               lane_x,
	input  elem_t               lane_y,
	input  elem_t               lane_z,
	output elem_t               out_x_s5,
	output elem_t               out_y_s5,
	output elem_t               out_z_s5
);

	// Zero a value whose magnitude falls below the threshold.
	function automatic elem_t squash(input elem_t v, input logic [THR_BITS-1:0] thr);
		logic [ELEMENT_BITS-1:0] mag;
		mag = v[ELEMENT_BITS-1] ? (~v + 1'b1) : v;
		return (mag < ELEMENT_BITS'(thr)) ? '0 : v;
	endfunction

	// Stage 5: output register.
	always_ff @(posedge clk) begin
		if (en.s5) begin
			out_x_s5 <= squash(lane_x, threshold);
			out_y_s5 <= squash(lane_y, threshold);
			out_z_s5 <= squash(lane_z, threshold);
		end
	end

endmodule

/* rtl/axis_rotation_3d.sv */
`timescale 1ns / 1ps
// Top level of the axis rotation block: handshake pipeline, configuration
// register and lane operand selection. Depends on ar3d_pkg, the channel
// interfaces, ar3d_sincos, ar3d_lane and ar3d_merge.
//
//   Channel   Kind        Carries
//   rows      sink        operation, angle, row_x, row_y, row_z
//   results   source      out_x, out_y, out_z
//   APB       cfg slave   zero_threshold at byte address 0
//
// One item per cycle sustained while results.ready holds. An item passes five
// register stages (two table stages, multiply, round and saturate,
// threshold), and its result is offered from the last of them.
// Every stage moves forward when it is empty or the stage after it moves, so
// bubbles close up and rows.ready drops only when all five stages are full
// and the result waits. Reset clears the stage valid bits and the threshold.

module axis_rotation_3d import ar3d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	ar3d_in_if.sink               rows,
	ar3d_out_if.source            results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0]  pwdata,
	output logic [DATA_BITS-1:0]  prdata,
	output logic                  pready
);

	stage_en_t               en;
	logic                    valid_s1;
	logic                    valid_s2;
	logic                    valid_s3;
	logic                    valid_s4;
	logic                    valid_s5;
	logic [THR_BITS-1:0]     threshold_q;
	logic [REG_INDEX_BITS-1:0] reg_index;

	logic [OP_BITS-1:0]      op_s1;
	elem_t                   x_s1;
	elem_t                   y_s1;
	elem_t                   z_s1;
	logic [OP_BITS-1:0]      op_s2;
	elem_t                   x_s2;
	elem_t                   y_s2;
	elem_t                   z_s2;

	coef_t                   sin_s2;
	coef_t                   cos_s2;
	lane_op_t                opnd_x;
	lane_op_t                opnd_y;
	lane_op_t                opnd_z;
	elem_t                   lane_x_s4;
	elem_t                   lane_y_s4;
	elem_t                   lane_z_s4;

	// Configuration register access.
	assign pready    = 1'b1;
	assign reg_index = paddr[PADDR_BITS-1:2];
	assign prdata    = (reg_index == REG_ZERO_THRESHOLD) ? DATA_BITS'(threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& reg_index == REG_ZERO_THRESHOLD) begin
			threshold_q <= pwdata[THR_BITS-1:0];
		end
	end

	// Stage advance strobes, from the output back to the input.
	always_comb begin
		en.s5 = !valid_s5 || results.ready;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign rows.ready    = en.s1;
	assign results.valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= rows.valid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
			if (en.s4) begin
				valid_s4 <= valid_s3;
			end
			if (en.s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Row and selector travel alongside the table lookup.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			op_s1 <= rows.operation;
			x_s1  <= rows.row_x;
			y_s1  <= rows.row_y;
			z_s1  <= rows.row_z;
		end
		if (en.s2) begin
			op_s2 <= op_s1;
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			z_s2  <= z_s1;
		end
	end

	ar3d_sincos u_sincos (
		.clk    (clk),
		.en     (en),
		.angle  (rows.angle),
		.sin_s2 (sin_s2),
		.cos_s2 (cos_s2)
	);

	// Lane operands per axis; a pass-through lane multiplies by exactly one.
	always_comb begin
		opnd_x = '{c1: COEF_ONE, e1: x_s2, c2: '0, e2: x_s2};
		opnd_y = '{c1: COEF_ONE, e1: y_s2, c2: '0, e2: y_s2};
		opnd_z = '{c1: COEF_ONE, e1: z_s2, c2: '0, e2: z_s2};
		case (op_t'(op_s2))
			OP_ROLL: begin
				opnd_y = '{c1: cos_s2, e1: y_s2, c2: -sin_s2, e2: z_s2};
				opnd_z = '{c1: sin_s2, e1: y_s2, c2: cos_s2, e2: z_s2};
			end
			OP_PITCH: begin
				opnd_x = '{c1: cos_s2, e1: x_s2, c2: sin_s2, e2: z_s2};
				opnd_z = '{c1: -sin_s2, e1: x_s2, c2: cos_s2, e2: z_s2};
			end
			OP_YAW: begin
				opnd_x = '{c1: cos_s2, e1: x_s2, c2: -sin_s2, e2: y_s2};
				opnd_y = '{c1: sin_s2, e1: x_s2, c2: cos_s2, e2: y_s2};
			end
			OP_IDENT: begin
				opnd_x = '{c1: COEF_ONE, e1: x_s2, c2: '0, e2: x_s2};
			end
			default: begin
				opnd_x = '{c1: COEF_ONE, e1: x_s2, c2: '0, e2: x_s2};
			end
		endcase
	end

	ar3d_lane u_lane_x (
		.clk    (clk),
		.en     (en),
		.opnd   (opnd_x),
		.sat_s4 (lane_x_s4)
	);

	ar3d_lane u_lane_y (
		.clk    (clk),
		.en     (en),
		.opnd   (opnd_y),
		.sat_s4 (lane_y_s4)
	);

	ar3d_lane u_lane_z (
		.clk    (clk),
		.en     (en),
		.opnd   (opnd_z),
		.sat_s4 (lane_z_s4)
	);

	ar3d_merge u_merge (
		.clk       (clk),
		.en        (en),
		.threshold (threshold_q),
		.lane_x    (lane_x_s4),
		.lane_y    (lane_y_s4),
		.lane_z    (lane_z_s4),
		.out_x_s5  (results.out_x),
		.out_y_s5  (results.out_y),
		.out_z_s5  (results.out_z)
	);

endmodule
